FILE: hw/rtl/dss_pkg.sv
package dss_pkg;

  typedef enum logic [3:0] {
    OP_INIT           = 4'd0,
    OP_BEGIN_STARTUP  = 4'd1,
    OP_FINISH_STARTUP = 4'd2,
    OP_RUN_REQ        = 4'd3,
    OP_OPEN_LOOP_REQ  = 4'd4,
    OP_STOP           = 4'd5,
    OP_TIMEOUT        = 4'd6,
    OP_ISR_STOP       = 4'd7,
    OP_LATCH_ESTOP    = 4'd8,
    OP_CLEAR_ESTOP    = 4'd9,
    OP_INTERNAL_FAULT = 4'd10,
    OP_QUERY          = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    MODE_STOPPED   = 3'd0,
    MODE_STARTING  = 3'd1,
    MODE_RUNNING   = 3'd2,
    MODE_OPEN_LOOP = 3'd3,
    MODE_TIMEOUT   = 3'd4,
    MODE_FAULT     = 3'd5,
    MODE_ESTOP     = 3'd6
  } mode_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       estop_level;
    logic       cmd_present;
    logic       critical_fault;
  } event_t;

  typedef struct packed {
    logic  granted;
    mode_t requested_mode;
    mode_t effective_mode;
    logic  estop_latched;
    logic  raise_estop_fault;
    logic  clear_estop_fault;
    logic  raise_timeout_fault;
    logic  clear_timeout_fault;
  } result_t;

endpackage

FILE: hw/rtl/drive_safety_supervisor.sv
// Drive safety supervisor: each request carries one event and yields exactly one
// result, presented through the input register and then the result register.
// A new request can be taken every cycle unless the output stalls; throughput is
// one event per cycle, set by the single pass through the decision logic that
// updates the emergency-stop latch and the requested mode. Fault pulses on the
// result apply to that event only and are meant for an external fault manager.
module drive_safety_supervisor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] opcode,
  input  logic       estop_level,
  input  logic       cmd_present,
  input  logic       critical_fault,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       granted,
  output logic [2:0] requested_mode,
  output logic [2:0] effective_mode,
  output logic       estop_latched,
  output logic       raise_estop_fault,
  output logic       clear_estop_fault,
  output logic       raise_timeout_fault,
  output logic       clear_timeout_fault
);

  logic             ev_valid;
  dss_pkg::event_t  ev;
  logic             latch;
  dss_pkg::mode_t   mode;
  dss_pkg::result_t res;
  dss_pkg::result_t res_q;
  logic             advance;

  // The result register moves when it is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = ev_valid && !advance;

  dss_decide u_decide (
    .ev    (ev),
    .latch (latch),
    .mode  (mode),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
      latch     <= 1'b0;
      mode      <= dss_pkg::MODE_STOPPED;
    end else begin
      if (advance) begin
        out_valid <= ev_valid;
        if (ev_valid) begin
          latch <= res.estop_latched;
          mode  <= res.requested_mode;
        end
      end
      if (!in_stall) begin
        ev_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev.opcode         <= opcode;
      ev.estop_level    <= estop_level;
      ev.cmd_present    <= cmd_present;
      ev.critical_fault <= critical_fault;
    end
    if (advance && ev_valid) begin
      res_q <= res;
    end
  end

  assign granted             = res_q.granted;
  assign requested_mode      = res_q.requested_mode;
  assign effective_mode      = res_q.effective_mode;
  assign estop_latched       = res_q.estop_latched;
  assign raise_estop_fault   = res_q.raise_estop_fault;
  assign clear_estop_fault   = res_q.clear_estop_fault;
  assign raise_timeout_fault = res_q.raise_timeout_fault;
  assign clear_timeout_fault = res_q.clear_timeout_fault;

endmodule

FILE: hw/rtl/dss_decide.sv
module dss_decide (
  input  dss_pkg::event_t  ev,
  input  logic             latch,
  input  dss_pkg::mode_t   mode,
  output dss_pkg::result_t res
);

  logic           grant;
  logic           latch_next;
  dss_pkg::mode_t mode_next;
  logic           r_es;
  logic           c_es;
  logic           r_to;
  logic           c_to;

  always_comb begin
    grant      = 1'b1;
    latch_next = latch;
    mode_next  = mode;
    r_es       = 1'b0;
    c_es       = 1'b0;
    r_to       = 1'b0;
    c_to       = 1'b0;
    unique case (ev.opcode)
      dss_pkg::OP_INIT: begin
        latch_next = ev.estop_level;
        mode_next  = dss_pkg::MODE_STOPPED;
        r_es       = ev.estop_level;
      end
      dss_pkg::OP_BEGIN_STARTUP: begin
        latch_next = 1'b0;
        mode_next  = dss_pkg::MODE_STARTING;
      end
      dss_pkg::OP_FINISH_STARTUP: begin
        latch_next = ev.estop_level;
        mode_next  = dss_pkg::MODE_STOPPED;
        r_es       = ev.estop_level;
        c_es       = ~ev.estop_level;
      end
      dss_pkg::OP_RUN_REQ: begin
        if (!ev.cmd_present || mode == dss_pkg::MODE_STARTING || latch ||
            ev.critical_fault || mode == dss_pkg::MODE_OPEN_LOOP) begin
          grant = 1'b0;
        end else begin
          c_to      = 1'b1;
          mode_next = dss_pkg::MODE_RUNNING;
        end
      end
      dss_pkg::OP_OPEN_LOOP_REQ: begin
        if (latch || ev.critical_fault || mode == dss_pkg::MODE_RUNNING ||
            mode == dss_pkg::MODE_OPEN_LOOP || mode == dss_pkg::MODE_STARTING) begin
          grant = 1'b0;
        end else begin
          mode_next = dss_pkg::MODE_OPEN_LOOP;
        end
      end
      dss_pkg::OP_STOP: begin
        mode_next = dss_pkg::MODE_STOPPED;
      end
      dss_pkg::OP_TIMEOUT: begin
        r_to      = 1'b1;
        mode_next = dss_pkg::MODE_TIMEOUT;
      end
      dss_pkg::OP_ISR_STOP: begin
        if (mode != dss_pkg::MODE_STARTING) begin
          mode_next = dss_pkg::MODE_STOPPED;
        end
      end
      dss_pkg::OP_LATCH_ESTOP: begin
        latch_next = 1'b1;
        r_es       = 1'b1;
      end
      dss_pkg::OP_CLEAR_ESTOP: begin
        if (latch) begin
          latch_next = 1'b0;
          c_es       = 1'b1;
          mode_next  = dss_pkg::MODE_STOPPED;
        end
      end
      dss_pkg::OP_INTERNAL_FAULT: begin
        mode_next = dss_pkg::MODE_FAULT;
      end
      default: begin
        // Query and the unused codes leave everything as it is.
      end
    endcase

    res.granted             = grant;
    res.requested_mode      = mode_next;
    res.estop_latched       = latch_next;
    res.raise_estop_fault   = r_es;
    res.clear_estop_fault   = c_es;
    res.raise_timeout_fault = r_to;
    res.clear_timeout_fault = c_to;
    if (latch_next) begin
      res.effective_mode = dss_pkg::MODE_ESTOP;
    end else if (ev.critical_fault) begin
      res.effective_mode = dss_pkg::MODE_FAULT;
    end else begin
      res.effective_mode = mode_next;
    end
  end

endmodule

FILE: sim/tb.sv
module tb;

  localparam logic [3:0] OP_UNUSED_LO = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int RANDOM_EVENTS = 1750;
  localparam int HOLD_OFF_CYCLES = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] opcode = dss_pkg::OP_QUERY;
  logic       estop_level = 1'b0;
  logic       cmd_present = 1'b0;
  logic       critical_fault = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       granted;
  logic [2:0] requested_mode;
  logic [2:0] effective_mode;
  logic       estop_latched;
  logic       raise_estop_fault;
  logic       clear_estop_fault;
  logic       raise_timeout_fault;
  logic       clear_timeout_fault;

  dss_pkg::event_t  pending_events[$];
  dss_pkg::result_t expected_results[$];
  dss_pkg::event_t  offered_event;
  int      total_events = 0;
  int      sent_count = 0;
  int      mismatch_count = 0;
  logic    hold_off = 1'b0;

  // Shadow copy of the supervisor state.
  logic           estop_latch_q = 1'b0;
  dss_pkg::mode_t mode_req_q = dss_pkg::MODE_STOPPED;

  drive_safety_supervisor u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .opcode              (opcode),
    .estop_level         (estop_level),
    .cmd_present         (cmd_present),
    .critical_fault      (critical_fault),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .granted             (granted),
    .requested_mode      (requested_mode),
    .effective_mode      (effective_mode),
    .estop_latched       (estop_latched),
    .raise_estop_fault   (raise_estop_fault),
    .clear_estop_fault   (clear_estop_fault),
    .raise_timeout_fault (raise_timeout_fault),
    .clear_timeout_fault (clear_timeout_fault)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic dss_pkg::result_t supervise_event(dss_pkg::event_t ev);
    dss_pkg::result_t r;
    r = '0;
    r.granted = 1'b1;
    case (ev.opcode)
      dss_pkg::OP_INIT: begin
        estop_latch_q = ev.estop_level;
        mode_req_q = dss_pkg::MODE_STOPPED;
        r.raise_estop_fault = ev.estop_level;
      end
      dss_pkg::OP_BEGIN_STARTUP: begin
        estop_latch_q = 1'b0;
        mode_req_q = dss_pkg::MODE_STARTING;
      end
      dss_pkg::OP_FINISH_STARTUP: begin
        estop_latch_q = ev.estop_level;
        mode_req_q = dss_pkg::MODE_STOPPED;
        r.raise_estop_fault = ev.estop_level;
        r.clear_estop_fault = !ev.estop_level;
      end
      dss_pkg::OP_RUN_REQ: begin
        if (!ev.cmd_present || mode_req_q == dss_pkg::MODE_STARTING || estop_latch_q ||
            ev.critical_fault || mode_req_q == dss_pkg::MODE_OPEN_LOOP) begin
          r.granted = 1'b0;
        end else begin
          r.clear_timeout_fault = 1'b1;
          mode_req_q = dss_pkg::MODE_RUNNING;
        end
      end
      dss_pkg::OP_OPEN_LOOP_REQ: begin
        if (estop_latch_q || ev.critical_fault || mode_req_q == dss_pkg::MODE_RUNNING ||
            mode_req_q == dss_pkg::MODE_OPEN_LOOP ||
            mode_req_q == dss_pkg::MODE_STARTING) begin
          r.granted = 1'b0;
        end else begin
          mode_req_q = dss_pkg::MODE_OPEN_LOOP;
        end
      end
      dss_pkg::OP_STOP: mode_req_q = dss_pkg::MODE_STOPPED;
      dss_pkg::OP_TIMEOUT: begin
        r.raise_timeout_fault = 1'b1;
        mode_req_q = dss_pkg::MODE_TIMEOUT;
      end
      dss_pkg::OP_ISR_STOP: begin
        if (mode_req_q != dss_pkg::MODE_STARTING) mode_req_q = dss_pkg::MODE_STOPPED;
      end
      dss_pkg::OP_LATCH_ESTOP: begin
        estop_latch_q = 1'b1;
        r.raise_estop_fault = 1'b1;
      end
      dss_pkg::OP_CLEAR_ESTOP: begin
        if (estop_latch_q) begin
          estop_latch_q = 1'b0;
          r.clear_estop_fault = 1'b1;
          mode_req_q = dss_pkg::MODE_STOPPED;
        end
      end
      dss_pkg::OP_INTERNAL_FAULT: mode_req_q = dss_pkg::MODE_FAULT;
      default: ;
    endcase
    r.requested_mode = mode_req_q;
    r.effective_mode = estop_latch_q ? dss_pkg::MODE_ESTOP :
                       (ev.critical_fault ? dss_pkg::MODE_FAULT : mode_req_q);
    r.estop_latched = estop_latch_q;
    return r;
  endfunction

  task automatic add_event(logic [3:0] op, logic lvl, logic cmd, logic crit);
    dss_pkg::event_t ev;
    ev.opcode = op;
    ev.estop_level = lvl;
    ev.cmd_present = cmd;
    ev.critical_fault = crit;
    pending_events.push_back(ev);
  endtask

  task automatic compare_field(string field, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // The first third idles the sender lightly and the receiver heavily, the
  // second third swaps the two, and the last third runs at full rate.
  function automatic int sender_idle_pct();
    if (sent_count * 3 < total_events) return 34;
    if (sent_count * 3 < total_events * 2) return 67;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_count * 3 < total_events) return 67;
    if (sent_count * 3 < total_events * 2) return 34;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(supervise_event(offered_event));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          offered_event = pending_events.pop_front();
          in_valid <= 1'b1;
          opcode <= offered_event.opcode;
          estop_level <= offered_event.estop_level;
          cmd_present <= offered_event.cmd_present;
          critical_fault <= offered_event.critical_fault;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    dss_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, got mode %0d",
                   $time, requested_mode);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("granted", 3'(want.granted), 3'(granted));
          compare_field("requested_mode", want.requested_mode, requested_mode);
          compare_field("effective_mode", want.effective_mode, effective_mode);
          compare_field("estop_latched", 3'(want.estop_latched), 3'(estop_latched));
          compare_field("raise_estop_fault", 3'(want.raise_estop_fault),
                        3'(raise_estop_fault));
          compare_field("clear_estop_fault", 3'(want.clear_estop_fault),
                        3'(clear_estop_fault));
          compare_field("raise_timeout_fault", 3'(want.raise_timeout_fault),
                        3'(raise_timeout_fault));
          compare_field("clear_timeout_fault", 3'(want.clear_timeout_fault),
                        3'(clear_timeout_fault));
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // Hold the output off during the full-rate phase so the block backs up.
  initial begin
    @(negedge rst);
    while (total_events == 0 || sent_count * 6 < total_events * 5) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n;
    logic [3:0] op;
    // Walk through every event and each refusal reason except an open-loop request made while already in open loop.
    add_event(dss_pkg::OP_INIT, 1'b1, 1'b0, 1'b0);
    add_event(dss_pkg::OP_RUN_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_OPEN_LOOP_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_CLEAR_ESTOP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_CLEAR_ESTOP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_INIT, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_BEGIN_STARTUP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_RUN_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_OPEN_LOOP_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_ISR_STOP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_FINISH_STARTUP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_RUN_REQ, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_RUN_REQ, 1'b0, 1'b1, 1'b1);
    add_event(dss_pkg::OP_RUN_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_OPEN_LOOP_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_ISR_STOP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_OPEN_LOOP_REQ, 1'b0, 1'b0, 1'b1);
    add_event(dss_pkg::OP_OPEN_LOOP_REQ, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_RUN_REQ, 1'b0, 1'b1, 1'b0);
    add_event(dss_pkg::OP_TIMEOUT, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_INTERNAL_FAULT, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_QUERY, 1'b0, 1'b0, 1'b1);
    add_event(OP_UNUSED_HI, 1'b1, 1'b1, 1'b1);
    add_event(dss_pkg::OP_BEGIN_STARTUP, 1'b1, 1'b1, 1'b1);
    add_event(dss_pkg::OP_FINISH_STARTUP, 1'b1, 1'b0, 1'b0);
    add_event(dss_pkg::OP_LATCH_ESTOP, 1'b0, 1'b0, 1'b0);
    add_event(dss_pkg::OP_STOP, 1'b0, 1'b0, 1'b0);

    // Random part: mostly free events, with startup sequences mixed in so
    // that run and open-loop requests often find the block ready.
    n = 0;
    while (n < RANDOM_EVENTS) begin
      if ($urandom_range(4) == 0) begin
        add_event(dss_pkg::OP_BEGIN_STARTUP, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        add_event(dss_pkg::OP_FINISH_STARTUP, $urandom_range(4) == 0,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        add_event($urandom_range(1) ? dss_pkg::OP_RUN_REQ : dss_pkg::OP_OPEN_LOOP_REQ,
                  1'($urandom_range(1)), 1'b1, $urandom_range(5) == 0);
        n += 3;
      end else begin
        if ($urandom_range(9) == 0) op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else op = 4'($urandom_range(dss_pkg::OP_QUERY, dss_pkg::OP_INIT));
        add_event(op, 1'($urandom_range(1)), $urandom_range(9) < 7,
                  $urandom_range(3) == 0);
        n++;
      end
    end
    total_events = pending_events.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_decide.sv
hw/rtl/drive_safety_supervisor.sv
sim/tb.sv
